>>> rtl/ip_acl_order_check_macros.svh
// Assertion macros shared by the access control list RTL.
`ifndef IP_ACL_ORDER_CHECK_MACROS_SVH
`define IP_ACL_ORDER_CHECK_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define AOC_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Antecedent implies consequent in the same cycle.
`define AOC_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle.
`define AOC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/aoc_pkg.sv
// Types and codes of the access control list order checker.
package aoc_pkg;

    localparam logic       CMD_WRITE = 1'b0;
    localparam logic       CMD_CHECK = 1'b1;

    localparam logic [1:0] KIND_NEVER = 2'd0;
    localparam logic [1:0] KIND_ALL   = 2'd1;
    localparam logic [1:0] KIND_V4    = 2'd2;
    localparam logic [1:0] KIND_V6    = 2'd3;

    localparam logic [1:0] DEC_NO_RULES    = 2'd0;
    localparam logic [1:0] DEC_FORCE_DENY  = 2'd1;
    localparam logic [1:0] DEC_FORCE_GRANT = 2'd2;
    localparam logic [1:0] DEC_TABLE       = 2'd3;

    localparam logic [2:0] CFG_ORDER_MODE  = 3'd0;
    localparam logic [2:0] CFG_ACL_ENABLED = 3'd1;
    localparam logic [2:0] CFG_FORCE_DENY  = 3'd2;
    localparam logic [2:0] CFG_FORCE_GRANT = 3'd3;
    localparam logic [2:0] CFG_ENTRY_COUNT = 3'd4;

    localparam logic [7:0] PREFIX_MAX_V4 = 8'd32;
    localparam logic [7:0] PREFIX_MAX_V6 = 8'd128;

    typedef struct packed {
        logic valid;
        logic any_allow;
        logic any_deny;
    } t_chain;

endpackage

>>> rtl/aoc_cell.sv
// One table entry with its match logic and one stage of the check chain.
module aoc_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    input  logic           i_in_use,
    input  logic [1:0]     i_kind,
    input  logic           i_allow,
    input  logic [7:0]     i_prefix,
    input  logic [63:0]    i_addr_hi,
    input  logic [63:0]    i_addr_lo,
    input  logic           i_cli6,
    input  logic [63:0]    i_cli_hi,
    input  logic [63:0]    i_cli_lo,
    input  aoc_pkg::t_chain i_chain,
    output aoc_pkg::t_chain o_chain
);

    logic [1:0]      r_kind;
    logic            r_allow;
    logic [7:0]      r_prefix;
    logic [63:0]     r_addr_hi;
    logic [63:0]     r_addr_lo;
    aoc_pkg::t_chain r_chain;

    logic [127:0]    w_mask6;
    logic [31:0]     w_mask4;
    logic            w_hit6;
    logic            w_hit4;
    logic            w_match;
    logic            w_count;

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_kind    <= i_kind;
            r_allow   <= i_allow;
            r_prefix  <= i_prefix;
            r_addr_hi <= i_addr_hi;
            r_addr_lo <= i_addr_lo;
        end
    end

    always_comb begin
        w_mask6 = ~({128{1'b1}} >> r_prefix);
        w_mask4 = ~({32{1'b1}} >> r_prefix);
        w_hit6  = i_cli6 && (r_prefix <= aoc_pkg::PREFIX_MAX_V6)
                  && ((({i_cli_hi, i_cli_lo} ^ {r_addr_hi, r_addr_lo}) & w_mask6) == '0);
        w_hit4  = !i_cli6 && (r_prefix <= aoc_pkg::PREFIX_MAX_V4)
                  && (((i_cli_lo[31:0] ^ r_addr_lo[31:0]) & w_mask4) == '0);
        case (r_kind)
            aoc_pkg::KIND_NEVER: w_match = 1'b0;
            aoc_pkg::KIND_ALL:   w_match = 1'b1;
            aoc_pkg::KIND_V4:    w_match = w_hit4;
            aoc_pkg::KIND_V6:    w_match = w_hit6;
            default:             w_match = 1'b0;
        endcase
        w_count = i_chain.valid && i_in_use && w_match;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chain <= '0;
        end else begin
            r_chain.valid     <= i_chain.valid;
            r_chain.any_allow <= i_chain.any_allow | (w_count & r_allow);
            r_chain.any_deny  <= i_chain.any_deny | (w_count & ~r_allow);
        end
    end

    assign o_chain = r_chain;

endmodule

>>> rtl/ip_acl_order_check.sv
// Allow/deny address table with ordered evaluation of client checks.
//
// Input channel: i_in_valid / o_in_stall carry one command per transaction:
// a table write or a client address check. Output channel: o_out_valid /
// i_out_stall carry one result per command, in command order.
// A write, and a check settled by forced deny, forced grant or no rules,
// is loaded into the output register in the cycle after acceptance.
// A check against the table walks a row of ACL_ENTRIES cells, one cell per
// cycle, each holding one entry, with S_HOLD keeping its result while the
// receiver stalls. One command is in work at a time: a table check stalls
// new commands until its result loads. The user must write configuration via
// i_cfg_we / i_cfg_index / i_cfg_data only while idle; the block does not
// enforce this. Reset clears the configuration and control state; table
// entries hold no value until written. While the receiver stalls, the
// result holds and new commands stall once the output register is full.
module ip_acl_order_check #(
    parameter int unsigned ACL_ENTRIES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_command,
    input  logic [3:0]  i_slot_index,
    input  logic [1:0]  i_entry_kind,
    input  logic        i_entry_is_allow,
    input  logic [7:0]  i_prefix_bits,
    input  logic [63:0] i_address_high,
    input  logic [63:0] i_address_low,
    input  logic        i_client_is_ipv6,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_is_write_ack,
    output logic        o_verdict,
    output logic [1:0]  o_decided_by,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [4:0]  i_cfg_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_HOLD
    } t_state;

    t_state          r_state;
    logic            r_order_mode;
    logic            r_acl_enabled;
    logic            r_force_deny;
    logic            r_force_grant;
    logic [4:0]      r_entry_count;
    logic            r_launch;
    logic            r_cli6;
    logic [63:0]     r_cli_hi;
    logic [63:0]     r_cli_lo;
    logic            r_hold_verdict;
    logic            r_out_valid;
    logic            r_out_ack;
    logic            r_out_verdict;
    logic [1:0]      r_out_decided;

    aoc_pkg::t_chain w_chain [0:ACL_ENTRIES];
    logic [ACL_ENTRIES:0] w_tok;
    logic [ACL_ENTRIES-1:0] w_wr;
    logic [ACL_ENTRIES-1:0] w_in_use;
    logic            w_out_free;
    logic            w_accept;
    logic            w_acc_write;
    logic            w_acc_check;
    logic            w_table;
    logic            w_done;
    logic            w_granted;
    logic            w_load;

    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall  = !((r_state == S_IDLE) && w_out_free);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_acc_write = w_accept && (i_command == aoc_pkg::CMD_WRITE);
    assign w_acc_check = w_accept && (i_command == aoc_pkg::CMD_CHECK);
    assign w_table     = r_acl_enabled && !r_force_deny && !r_force_grant;
    assign w_load      = w_acc_write || (w_acc_check && !w_table)
                         || ((r_state == S_WALK) && w_done && w_out_free)
                         || ((r_state == S_HOLD) && w_out_free);

    assign w_chain[0] = '{valid: r_launch, any_allow: 1'b0, any_deny: 1'b0};
    assign w_done     = w_chain[ACL_ENTRIES].valid;
    assign w_granted  = r_order_mode
                        ? (w_chain[ACL_ENTRIES].any_allow && !w_chain[ACL_ENTRIES].any_deny)
                        : (w_chain[ACL_ENTRIES].any_allow || !w_chain[ACL_ENTRIES].any_deny);

    for (genvar g = 0; g <= ACL_ENTRIES; g++) begin : g_tok
        assign w_tok[g] = w_chain[g].valid;
    end

    for (genvar g = 0; g < ACL_ENTRIES; g++) begin : g_cell
        assign w_wr[g]     = w_acc_write && (32'(i_slot_index) == g);
        assign w_in_use[g] = 32'(r_entry_count) > g;

        aoc_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_wr      (w_wr[g]),
            .i_in_use  (w_in_use[g]),
            .i_kind    (i_entry_kind),
            .i_allow   (i_entry_is_allow),
            .i_prefix  (i_prefix_bits),
            .i_addr_hi (i_address_high),
            .i_addr_lo (i_address_low),
            .i_cli6    (r_cli6),
            .i_cli_hi  (r_cli_hi),
            .i_cli_lo  (r_cli_lo),
            .i_chain   (w_chain[g]),
            .o_chain   (w_chain[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order_mode  <= 1'b0;
            r_acl_enabled <= 1'b0;
            r_force_deny  <= 1'b0;
            r_force_grant <= 1'b0;
            r_entry_count <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                aoc_pkg::CFG_ORDER_MODE:  r_order_mode  <= i_cfg_data[0];
                aoc_pkg::CFG_ACL_ENABLED: r_acl_enabled <= i_cfg_data[0];
                aoc_pkg::CFG_FORCE_DENY:  r_force_deny  <= i_cfg_data[0];
                aoc_pkg::CFG_FORCE_GRANT: r_force_grant <= i_cfg_data[0];
                aoc_pkg::CFG_ENTRY_COUNT: r_entry_count <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc_check) begin
            r_cli6   <= i_client_is_ipv6;
            r_cli_hi <= i_address_high;
            r_cli_lo <= i_address_low;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_launch       <= 1'b0;
            r_out_valid    <= 1'b0;
            r_out_ack      <= 1'b0;
            r_out_verdict  <= 1'b0;
            r_out_decided  <= aoc_pkg::DEC_NO_RULES;
            r_hold_verdict <= 1'b0;
        end else begin
            r_launch <= w_acc_check && w_table;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_acc_write) begin
                        r_out_ack     <= 1'b1;
                        r_out_verdict <= 1'b0;
                        r_out_decided <= aoc_pkg::DEC_NO_RULES;
                    end else if (w_acc_check && w_table) begin
                        r_state  <= S_WALK;
                    end else if (w_acc_check) begin
                        r_out_ack   <= 1'b0;
                        if (r_force_deny) begin
                            r_out_verdict <= 1'b1;
                            r_out_decided <= aoc_pkg::DEC_FORCE_DENY;
                        end else if (r_force_grant) begin
                            r_out_verdict <= 1'b0;
                            r_out_decided <= aoc_pkg::DEC_FORCE_GRANT;
                        end else begin
                            r_out_verdict <= 1'b0;
                            r_out_decided <= aoc_pkg::DEC_NO_RULES;
                        end
                    end
                end
                S_WALK: begin
                    if (w_done) begin
                        if (w_out_free) begin
                            r_out_ack     <= 1'b0;
                            r_out_verdict <= !w_granted;
                            r_out_decided <= aoc_pkg::DEC_TABLE;
                            r_state       <= S_IDLE;
                        end else begin
                            r_hold_verdict <= !w_granted;
                            r_state        <= S_HOLD;
                        end
                    end
                end
                S_HOLD: begin
                    if (w_out_free) begin
                        r_out_ack     <= 1'b0;
                        r_out_verdict <= r_hold_verdict;
                        r_out_decided <= aoc_pkg::DEC_TABLE;
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_is_write_ack = r_out_ack;
    assign o_verdict      = r_out_verdict;
    assign o_decided_by   = r_out_decided;

`include "ip_acl_order_check_macros.svh"

    `AOC_ASSERT_ALWAYS(a_one_token, i_clk, i_rst_n, $countones(w_tok) <= 1,
                       "more than one check in the chain")
    `AOC_ASSERT_IMPLY(a_done_in_walk, i_clk, i_rst_n, w_done, r_state == S_WALK,
                      "chain result outside walk")
    `AOC_ASSERT_NEXT(a_table_launch, i_clk, i_rst_n, w_acc_check && w_table,
                     r_launch && (r_state == S_WALK), "table check did not launch")
    `AOC_ASSERT_IMPLY(a_busy_stalls, i_clk, i_rst_n, r_state != S_IDLE, o_in_stall,
                      "command accepted while busy")

endmodule

>>> bench/ip_acl_order_check_tb.sv
// Self-checking bench for the allow/deny address table: directed rows, then random phases.
`timescale 1ns / 100ps

module ip_acl_order_check_tb;

    localparam int   ACL_ENTRIES     = 16;
    localparam int   PHASES          = 14;
    localparam int   ITEMS_PER_PHASE = 56;
    localparam int   QUIET_LIMIT     = 5000;
    localparam logic GRANTED         = 1'b0;
    localparam logic FORBIDDEN       = 1'b1;

    typedef struct packed {
        logic        command;
        logic [3:0]  slot;
        logic [1:0]  kind;
        logic        allow;
        logic [7:0]  prefix;
        logic [63:0] addr_hi;
        logic [63:0] addr_lo;
        logic        ipv6;
    } t_acl_cmd;

    typedef struct packed {
        logic       ack;
        logic       verdict;
        logic [1:0] dec;
    } t_acl_outcome;

    typedef enum logic [1:0] {ROW_REG, ROW_CMD, ROW_FIXED} t_row_op;

    typedef struct packed {
        t_row_op      op;
        logic [2:0]   reg_idx;
        logic [4:0]   reg_val;
        t_acl_cmd     cmd;
        t_acl_outcome want;
    } t_dir_row;

    logic        i_clk            = 1'b0;
    logic        i_rst_n          = 1'b0;
    logic        i_in_valid       = 1'b0;
    logic        o_in_stall;
    logic        i_command        = 1'b0;
    logic [3:0]  i_slot_index     = '0;
    logic [1:0]  i_entry_kind     = '0;
    logic        i_entry_is_allow = 1'b0;
    logic [7:0]  i_prefix_bits    = '0;
    logic [63:0] i_address_high   = '0;
    logic [63:0] i_address_low    = '0;
    logic        i_client_is_ipv6 = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall      = 1'b0;
    logic        o_is_write_ack;
    logic        o_verdict;
    logic [1:0]  o_decided_by;
    logic        i_cfg_we         = 1'b0;
    logic [2:0]  i_cfg_index      = '0;
    logic [4:0]  i_cfg_data       = '0;

    // predictor copy of the table and the registers
    logic [1:0]  rule_kind  [ACL_ENTRIES];
    logic        rule_allow [ACL_ENTRIES];
    logic [7:0]  rule_len   [ACL_ENTRIES];
    logic [63:0] rule_hi    [ACL_ENTRIES];
    logic [63:0] rule_lo    [ACL_ENTRIES];
    logic        mode_allow_first = 1'b0;
    logic        acl_on           = 1'b0;
    logic        deny_all         = 1'b0;
    logic        grant_all        = 1'b0;
    logic [4:0]  rules_in_use     = '0;

    t_acl_outcome pending[$];
    t_dir_row     dir_rows[$];
    int           fault_count  = 0;
    int           quiet_cycles = 0;
    int           idle_pct     = 0;
    int           stall_pct    = 0;

    ip_acl_order_check #(
        .ACL_ENTRIES(ACL_ENTRIES)
    ) u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_command        (i_command),
        .i_slot_index     (i_slot_index),
        .i_entry_kind     (i_entry_kind),
        .i_entry_is_allow (i_entry_is_allow),
        .i_prefix_bits    (i_prefix_bits),
        .i_address_high   (i_address_high),
        .i_address_low    (i_address_low),
        .i_client_is_ipv6 (i_client_is_ipv6),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_is_write_ack   (o_is_write_ack),
        .o_verdict        (o_verdict),
        .o_decided_by     (o_decided_by),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    function automatic t_acl_outcome decide_access(t_acl_cmd c);
        t_acl_outcome r;
        logic         any_allow;
        logic         any_deny;
        logic         hit;
        logic [31:0]  m4;
        logic [127:0] m6;
        int           n;
        int           len;
        r = '0;
        r.verdict = GRANTED;
        r.dec = aoc_pkg::DEC_NO_RULES;
        any_allow = 1'b0;
        any_deny = 1'b0;
        if (c.command == aoc_pkg::CMD_WRITE) begin
            rule_kind[c.slot] = c.kind;
            rule_allow[c.slot] = c.allow;
            rule_len[c.slot] = c.prefix;
            rule_hi[c.slot] = c.addr_hi;
            rule_lo[c.slot] = c.addr_lo;
            r.ack = 1'b1;
        end else if (deny_all) begin
            r.verdict = FORBIDDEN;
            r.dec = aoc_pkg::DEC_FORCE_DENY;
        end else if (grant_all) begin
            r.dec = aoc_pkg::DEC_FORCE_GRANT;
        end else if (acl_on) begin
            n = (rules_in_use > ACL_ENTRIES) ? ACL_ENTRIES : int'(rules_in_use);
            for (int i = 0; i < n; i++) begin
                len = int'(rule_len[i]);
                m4 = (len == 0 || len > 32) ? '0 : (~32'h0 << (32 - len));
                m6 = (len == 0 || len > 128) ? '0 : (~128'h0 << (128 - len));
                case (rule_kind[i])
                    aoc_pkg::KIND_ALL: hit = 1'b1;
                    aoc_pkg::KIND_V4: hit = !c.ipv6 && len <= 32
                        && (((c.addr_lo[31:0] ^ rule_lo[i][31:0]) & m4) == '0);
                    aoc_pkg::KIND_V6: hit = c.ipv6 && len <= 128
                        && ((({c.addr_hi, c.addr_lo} ^ {rule_hi[i], rule_lo[i]}) & m6) == '0);
                    default: hit = 1'b0;
                endcase
                if (hit && rule_allow[i]) any_allow = 1'b1;
                if (hit && !rule_allow[i]) any_deny = 1'b1;
            end
            r.dec = aoc_pkg::DEC_TABLE;
            if (mode_allow_first) r.verdict = (any_allow && !any_deny) ? GRANTED : FORBIDDEN;
            else r.verdict = (any_allow || !any_deny) ? GRANTED : FORBIDDEN;
        end
        return r;
    endfunction

    function automatic t_acl_cmd random_command();
        t_acl_cmd     c;
        logic [127:0] addr;
        int           s;
        c.command = ($urandom_range(99) < 35) ? aoc_pkg::CMD_WRITE : aoc_pkg::CMD_CHECK;
        c.slot = 4'($urandom_range(15));
        c.kind = 2'($urandom_range(3));
        c.allow = 1'($urandom_range(1));
        c.prefix = 8'($urandom_range(255));
        c.addr_hi = {$urandom, $urandom};
        c.addr_lo = {$urandom, $urandom};
        c.ipv6 = 1'($urandom_range(1));
        s = $urandom_range(ACL_ENTRIES - 1);
        addr = {rule_hi[s], rule_lo[s]};
        if (c.command == aoc_pkg::CMD_WRITE) begin
            if ($urandom_range(9) < 8)
                c.prefix = 8'($urandom_range(c.kind == aoc_pkg::KIND_V6 ? 128 : 32));
            if ($urandom_range(9) < 4) begin
                addr = addr ^ (128'b1 << $urandom_range(127));
                c.addr_hi = addr[127:64];
                c.addr_lo = addr[63:0];
            end
        end else if ($urandom_range(9) < 6) begin
            if (rule_kind[s] == aoc_pkg::KIND_V4 || rule_kind[s] == aoc_pkg::KIND_V6)
                c.ipv6 = (rule_kind[s] == aoc_pkg::KIND_V6);
            if ($urandom_range(1))
                addr = addr ^ (128'b1 << (c.ipv6 ? $urandom_range(127) : $urandom_range(31)));
            c.addr_hi = c.ipv6 ? addr[127:64] : c.addr_hi;
            c.addr_lo = c.ipv6 ? addr[63:0] : {c.addr_lo[63:32], addr[31:0]};
        end
        return c;
    endfunction

    function automatic t_dir_row reg_row(logic [2:0] idx, logic [4:0] val);
        t_dir_row r;
        r = '0;
        r.op = ROW_REG;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    function automatic t_dir_row write_row(logic [3:0] slot, logic [1:0] kind, logic allow,
                                           logic [7:0] pfx, logic [63:0] hi, logic [63:0] lo);
        t_dir_row r;
        r = '0;
        r.op = ROW_FIXED;
        r.cmd.command = aoc_pkg::CMD_WRITE;
        r.cmd.slot = slot;
        r.cmd.kind = kind;
        r.cmd.allow = allow;
        r.cmd.prefix = pfx;
        r.cmd.addr_hi = hi;
        r.cmd.addr_lo = lo;
        r.want.ack = 1'b1;
        r.want.verdict = GRANTED;
        r.want.dec = aoc_pkg::DEC_NO_RULES;
        return r;
    endfunction

    function automatic t_dir_row check_row(logic v6, logic [63:0] hi, logic [63:0] lo);
        t_dir_row r;
        r = '0;
        r.op = ROW_CMD;
        r.cmd.command = aoc_pkg::CMD_CHECK;
        r.cmd.ipv6 = v6;
        r.cmd.addr_hi = hi;
        r.cmd.addr_lo = lo;
        return r;
    endfunction

    function automatic t_dir_row fixed_check_row(logic v6, logic [63:0] hi, logic [63:0] lo,
                                                 logic verdict, logic [1:0] dec);
        t_dir_row r;
        r = check_row(v6, hi, lo);
        r.op = ROW_FIXED;
        r.want.verdict = verdict;
        r.want.dec = dec;
        return r;
    endfunction

    task automatic note_fault(input string what);
        fault_count++;
        if (fault_count <= 10) $display("%0t: %s", $time, what);
    endtask

    task automatic send_cmd(input t_acl_cmd c, input logic fixed, input t_acl_outcome want);
        t_acl_outcome guess;
        if ($urandom_range(49) == 0) begin
            // hold off until every result is back
            i_in_valid <= 1'b0;
            while (pending.size() != 0) @(posedge i_clk);
            @(negedge i_clk);
        end
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_command        <= c.command;
        i_slot_index     <= c.slot;
        i_entry_kind     <= c.kind;
        i_entry_is_allow <= c.allow;
        i_prefix_bits    <= c.prefix;
        i_address_high   <= c.addr_hi;
        i_address_low    <= c.addr_lo;
        i_client_is_ipv6 <= c.ipv6;
        i_in_valid       <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        guess = decide_access(c);
        pending.push_back(fixed ? want : guess);
        @(negedge i_clk);
    endtask

    task automatic set_reg(input logic [2:0] idx, input logic [4:0] val);
        i_in_valid <= 1'b0;
        while (pending.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            aoc_pkg::CFG_ORDER_MODE:  mode_allow_first = val[0];
            aoc_pkg::CFG_ACL_ENABLED: acl_on = val[0];
            aoc_pkg::CFG_FORCE_DENY:  deny_all = val[0];
            aoc_pkg::CFG_FORCE_GRANT: grant_all = val[0];
            aoc_pkg::CFG_ENTRY_COUNT: rules_in_use = val;
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        t_acl_outcome got;
        t_acl_outcome want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = {o_is_write_ack, o_verdict, o_decided_by};
            if (pending.size() == 0) begin
                note_fault($sformatf("unexpected result: ack=%0b verdict=%0b by=%0d",
                                     got.ack, got.verdict, got.dec));
            end else begin
                want = pending.pop_front();
                if (got !== want)
                    note_fault($sformatf({"result mismatch: expected ack=%0b verdict=%0b ",
                                          "by=%0d, got ack=%0b verdict=%0b by=%0d"},
                                         want.ack, want.verdict, want.dec,
                                         got.ack, got.verdict, got.dec));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        t_acl_cmd   c;
        t_dir_row   row;
        logic       ord;
        logic       en;
        logic       fd;
        logic       fg;
        logic [4:0] cnt;
        dir_rows.push_back(fixed_check_row(1'b0, '1, '0, GRANTED, aoc_pkg::DEC_NO_RULES));
        dir_rows.push_back(fixed_check_row(1'b1, '1, '1, GRANTED, aoc_pkg::DEC_NO_RULES));
        dir_rows.push_back(write_row(4'd0, aoc_pkg::KIND_V4, 1'b1, 8'd24, '1,
                                     64'hDEAD_BEEF_C0A8_0100));
        dir_rows.push_back(write_row(4'd1, aoc_pkg::KIND_V6, 1'b0, aoc_pkg::PREFIX_MAX_V6,
                                     64'h2001_0DB8_0000_0001, 64'h42));
        dir_rows.push_back(write_row(4'd2, aoc_pkg::KIND_NEVER, 1'b1, 8'hFF, '1, '1));
        dir_rows.push_back(write_row(4'd3, aoc_pkg::KIND_V4, 1'b0, 8'd0, '0, '0));
        dir_rows.push_back(write_row(4'd15, aoc_pkg::KIND_ALL, 1'b0, 8'd0, '0, '0));
        dir_rows.push_back(reg_row(aoc_pkg::CFG_ENTRY_COUNT, 5'd4));
        dir_rows.push_back(reg_row(aoc_pkg::CFG_ACL_ENABLED, 5'd1));
        dir_rows.push_back(check_row(1'b0, '1, 64'h1234_5678_C0A8_01FF));
        dir_rows.push_back(check_row(1'b0, '0, 64'h0A00_0001));
        dir_rows.push_back(check_row(1'b1, 64'h2001_0DB8_0000_0001, 64'h42));
        dir_rows.push_back(check_row(1'b1, 64'h2001_0DB8_0000_0001, 64'h43));
        dir_rows.push_back(check_row(1'b0, 64'h2001_0DB8_0000_0001, 64'h42));
        dir_rows.push_back(write_row(4'd2, aoc_pkg::KIND_V4, 1'b1,
                                     aoc_pkg::PREFIX_MAX_V4 + 8'd1, '0, '0));
        dir_rows.push_back(check_row(1'b0, '0, '0));
        dir_rows.push_back(write_row(4'd1, aoc_pkg::KIND_V6, 1'b1,
                                     aoc_pkg::PREFIX_MAX_V6 + 8'd1,
                                     64'h2001_0DB8_0000_0001, 64'h42));
        dir_rows.push_back(check_row(1'b1, 64'h2001_0DB8_0000_0001, 64'h42));
        dir_rows.push_back(reg_row(aoc_pkg::CFG_ORDER_MODE, 5'd1));
        dir_rows.push_back(check_row(1'b0, '0, 64'hC0A8_0105));
        dir_rows.push_back(write_row(4'd3, aoc_pkg::KIND_V6, 1'b0, 8'd0, '1, '1));
        dir_rows.push_back(check_row(1'b0, '0, 64'hC0A8_0105));
        dir_rows.push_back(check_row(1'b1, '1, '0));
        dir_rows.push_back(write_row(4'd2, aoc_pkg::KIND_ALL, 1'b1, 8'd0, '0, '0));
        dir_rows.push_back(check_row(1'b1, '0, '0));
        dir_rows.push_back(reg_row(aoc_pkg::CFG_FORCE_GRANT, 5'd1));
        dir_rows.push_back(fixed_check_row(1'b0, '0, '0, GRANTED, aoc_pkg::DEC_FORCE_GRANT));
        dir_rows.push_back(reg_row(aoc_pkg::CFG_FORCE_DENY, 5'd1));
        dir_rows.push_back(fixed_check_row(1'b1, '1, '1, FORBIDDEN, aoc_pkg::DEC_FORCE_DENY));
        dir_rows.push_back(reg_row(aoc_pkg::CFG_FORCE_GRANT, 5'd0));
        dir_rows.push_back(fixed_check_row(1'b0, '0, 64'hC0A8_0105, FORBIDDEN,
                                           aoc_pkg::DEC_FORCE_DENY));

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[k]) begin
            row = dir_rows[k];
            if (row.op == ROW_REG) set_reg(row.reg_idx, row.reg_val);
            else send_cmd(row.cmd, row.op == ROW_FIXED, row.want);
        end

        for (int p = 0; p < PHASES; p++) begin
            case (p % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 71; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 71; end
                default: begin idle_pct = 38; stall_pct = 38; end
            endcase
            case (p)
                0: {ord, en, fd, fg, cnt} = {4'b0000, 5'd0};
                1: {ord, en, fd, fg, cnt} = {4'b0100, 5'd16};
                2: {ord, en, fd, fg, cnt} = {4'b1100, 5'd16};
                3: {ord, en, fd, fg, cnt} = {4'b0100, 5'd31};
                4: {ord, en, fd, fg, cnt} = {4'b1100, 5'd1};
                5: {ord, en, fd, fg, cnt} = {4'b0100, 5'd0};
                6: {ord, en, fd, fg, cnt} = {4'b1100, 5'd0};
                7: {ord, en, fd, fg, cnt} = {4'b1110, 5'd16};
                8: {ord, en, fd, fg, cnt} = {4'b0101, 5'd8};
                9: {ord, en, fd, fg, cnt} = {4'b1000, 5'd31};
                default: begin
                    ord = 1'($urandom_range(1));
                    en  = 1'b1;
                    fd  = ($urandom_range(9) == 0);
                    fg  = ($urandom_range(9) == 0);
                    cnt = 5'($urandom_range(31));
                end
            endcase
            set_reg(aoc_pkg::CFG_ORDER_MODE, {4'b0, ord});
            set_reg(aoc_pkg::CFG_ACL_ENABLED, {4'b0, en});
            set_reg(aoc_pkg::CFG_FORCE_DENY, {4'b0, fd});
            set_reg(aoc_pkg::CFG_FORCE_GRANT, {4'b0, fg});
            set_reg(aoc_pkg::CFG_ENTRY_COUNT, cnt);
            if (p == 0) begin
                // fill every slot before the table is read
                for (int s = 0; s < ACL_ENTRIES; s++) begin
                    c = random_command();
                    c.command = aoc_pkg::CMD_WRITE;
                    c.slot = 4'(s);
                    c.addr_hi = {$urandom, $urandom};
                    c.addr_lo = {$urandom, $urandom};
                    send_cmd(c, 1'b0, '0);
                end
            end
            repeat (ITEMS_PER_PHASE) send_cmd(random_command(), 1'b0, '0);
        end

        i_in_valid <= 1'b0;
        while (pending.size() != 0) @(posedge i_clk);
        repeat (ACL_ENTRIES + 4) @(posedge i_clk);
        if (fault_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
